// ----- rtl/nsts_pkg.sv -----
// Package for the nearest sphere target select block.
// Holds the register index codes, fixed-point constants and shared types.
// Used by the top level and by its checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package nsts_pkg;

   localparam int COORD_W      = 32;
   localparam int DIST_W       = 31;
   localparam int FRAC_SHIFT   = 12;
   localparam int ACC_W        = COORD_W + FRAC_SHIFT;
   localparam int ID_BITS_DEF  = 16;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int PIPE_STAGES  = 5;

   localparam logic [DIST_W-1:0] DIST_INIT = {DIST_W{1'b1}};
   localparam logic [ACC_W-1:0]  ROUND_ADD = ACC_W'(1) << (FRAC_SHIFT - 1);

   localparam logic [CSR_IDX_W-1:0] CSR_SELECT_NEAREST = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SELF_X         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SELF_Y         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SELF_Z         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SELF_RADIUS    = 3'd4;

   typedef struct packed {
      logic qual;
      logic marked;
      logic last;
   } cand_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/nearest_sphere_target_select_top.sv -----
// Top level of the nearest sphere target select block.
// Five-stage pipeline computing squared surface distances and the selection register.
// Depends on nsts_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One candidate request is accepted per clock cycle while req_ready is high. Each candidate passes through
// five pipeline stages (centre differences, squares, sums, rounding, subtraction) and is
// then folded into the held selection, so the response register is loaded once the
// request that carries the last mark leaves stage five. Each term uses one 32 by 32 bit
// multiplier. A waiting response does not stop further requests until the pipeline
// fills behind it.
module nearest_sphere_target_select_top #(
   parameter int ID_BITS = nsts_pkg::ID_BITS_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_wr_en,
   input  wire [nsts_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire [nsts_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire signed [nsts_pkg::COORD_W-1:0]    req_cand_x,
   input  wire signed [nsts_pkg::COORD_W-1:0]    req_cand_y,
   input  wire signed [nsts_pkg::COORD_W-1:0]    req_cand_z,
   input  wire signed [nsts_pkg::COORD_W-1:0]    req_cand_radius,
   input  wire                                   req_cand_live,
   input  wire                                   req_cand_enabled,
   input  wire                                   req_cand_marked,
   input  wire [ID_BITS-1:0]                     req_cand_id,
   input  wire                                   req_last_item,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output logic                                  rsp_found,
   output logic [ID_BITS-1:0]                    rsp_best_id,
   output logic [nsts_pkg::DIST_W-1:0]           rsp_best_dist
);

   localparam int CW = nsts_pkg::COORD_W;
   localparam int AW = nsts_pkg::ACC_W;
   localparam int DW = nsts_pkg::DIST_W;
   localparam int NS = nsts_pkg::PIPE_STAGES;

   logic          select_nearest_ff;
   logic [CW-1:0] self_x_ff, self_y_ff, self_z_ff, self_radius_ff;

   logic [NS:1]               v_ff, v_in;
   nsts_pkg::cand_ctl_type    ctl_ff [1:NS];
   logic [ID_BITS-1:0]        id_ff  [1:NS];
   logic [NS:1]               load;
   logic                      take;

   logic [CW-1:0] dx_ff, dy_ff, dz_ff, crad_ff;
   logic [AW-1:0] sqx_ff, sqy_ff, sqz_ff, sqsr_ff, sqcr_ff;
   logic [AW-1:0] dsq_ff, rsq_ff;
   logic [CW-1:0] rd_ff, rr_ff;
   logic [DW-1:0] dist_ff;

   logic               have_ff, have_in;
   logic [ID_BITS-1:0] bid_ff, bid_in;
   logic [DW-1:0]      bdist_ff, bdist_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [ID_BITS-1:0] rsp_id_ff, rsp_id_in;
   logic [DW-1:0]      rsp_dist_ff, rsp_dist_in;

   logic signed [2*CW-1:0] px, py, pz, psr, pcr;
   logic [AW-1:0]          tdsq, trsq;
   logic [CW-1:0]          dsub;
   logic                   upd, nh;
   logic [ID_BITS-1:0]     nid;
   logic [DW-1:0]          nd;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         select_nearest_ff <= 1'b0;
         self_x_ff         <= '0;
         self_y_ff         <= '0;
         self_z_ff         <= '0;
         self_radius_ff    <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            nsts_pkg::CSR_SELECT_NEAREST: select_nearest_ff <= csr_wdata[0];
            nsts_pkg::CSR_SELF_X:         self_x_ff         <= csr_wdata[CW-1:0];
            nsts_pkg::CSR_SELF_Y:         self_y_ff         <= csr_wdata[CW-1:0];
            nsts_pkg::CSR_SELF_Z:         self_z_ff         <= csr_wdata[CW-1:0];
            nsts_pkg::CSR_SELF_RADIUS:    self_radius_ff    <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   // Elastic pipeline control
   always_comb begin
      take    = v_ff[5] && (!ctl_ff[5].last || !rsp_valid_ff || rsp_ready);
      load[5] = v_ff[4] && (!v_ff[5] || take);
      load[4] = v_ff[3] && (!v_ff[4] || load[5]);
      load[3] = v_ff[2] && (!v_ff[3] || load[4]);
      load[2] = v_ff[1] && (!v_ff[2] || load[3]);
      req_ready = !v_ff[1] || load[2];
      load[1] = req_valid && req_ready;
      v_in[1] = load[1] ? 1'b1 : (load[2] ? 1'b0 : v_ff[1]);
      v_in[2] = load[2] ? 1'b1 : (load[3] ? 1'b0 : v_ff[2]);
      v_in[3] = load[3] ? 1'b1 : (load[4] ? 1'b0 : v_ff[3]);
      v_in[4] = load[4] ? 1'b1 : (load[5] ? 1'b0 : v_ff[4]);
      v_in[5] = load[5] ? 1'b1 : (take    ? 1'b0 : v_ff[5]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         ctl_ff[1] <= '{qual:   req_cand_live && req_cand_enabled,
                        marked: req_cand_marked,
                        last:   req_last_item};
         id_ff[1]  <= req_cand_id;
      end
      for (int k = 2; k <= NS; k++) begin
         if (load[k]) begin
            ctl_ff[k] <= ctl_ff[k-1];
            id_ff[k]  <= id_ff[k-1];
         end
      end
   end

   // Datapath
   always_comb begin
      px   = $signed(dx_ff) * $signed(dx_ff);
      py   = $signed(dy_ff) * $signed(dy_ff);
      pz   = $signed(dz_ff) * $signed(dz_ff);
      psr  = $signed(self_radius_ff) * $signed(self_radius_ff);
      pcr  = $signed(crad_ff) * $signed(crad_ff);
      tdsq = dsq_ff + nsts_pkg::ROUND_ADD;
      trsq = rsq_ff + nsts_pkg::ROUND_ADD;
      dsub = rd_ff - rr_ff;
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         dx_ff   <= req_cand_x - self_x_ff;
         dy_ff   <= req_cand_y - self_y_ff;
         dz_ff   <= req_cand_z - self_z_ff;
         crad_ff <= req_cand_radius;
      end
      if (load[2]) begin
         sqx_ff  <= px[AW-1:0];
         sqy_ff  <= py[AW-1:0];
         sqz_ff  <= pz[AW-1:0];
         sqsr_ff <= psr[AW-1:0];
         sqcr_ff <= pcr[AW-1:0];
      end
      if (load[3]) begin
         dsq_ff <= sqx_ff + sqy_ff + sqz_ff;
         rsq_ff <= sqsr_ff + sqcr_ff;
      end
      if (load[4]) begin
         rd_ff <= tdsq[AW-1:nsts_pkg::FRAC_SHIFT];
         rr_ff <= trsq[AW-1:nsts_pkg::FRAC_SHIFT];
      end
      if (load[5]) begin
         dist_ff <= dsub[CW-1] ? '0 : dsub[DW-1:0];
      end
   end

   // Selection and response register
   always_comb begin
      upd = ctl_ff[5].qual &&
            (select_nearest_ff ? (dist_ff < bdist_ff) : (!have_ff && !ctl_ff[5].marked));
      nh  = upd || have_ff;
      nid = upd ? id_ff[5] : bid_ff;
      nd  = upd ? dist_ff : bdist_ff;

      have_in      = have_ff;
      bid_in       = bid_ff;
      bdist_in     = bdist_ff;
      rsp_found_in = rsp_found_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;

      if (take) begin
         if (ctl_ff[5].last) begin
            have_in      = 1'b0;
            bid_in       = '0;
            bdist_in     = nsts_pkg::DIST_INIT;
            rsp_valid_in = 1'b1;
            rsp_found_in = nh;
            rsp_id_in    = nh ? nid : '0;
            rsp_dist_in  = nh ? nd : '0;
         end else begin
            have_in  = nh;
            bid_in   = nid;
            bdist_in = nd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff      <= 1'b0;
         bid_ff       <= '0;
         bdist_ff     <= nsts_pkg::DIST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         have_ff      <= have_in;
         bid_ff       <= bid_in;
         bdist_ff     <= bdist_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_dist_ff  <= rsp_dist_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_best_id   = rsp_id_ff;
   assign rsp_best_dist = rsp_dist_ff;

endmodule

`default_nettype wire

// ----- rtl/nsts_checker.sv -----
// Port-level checker for the nearest sphere target select block, with its bind statement.
// Watches the response channel over time; depends on nsts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nsts_checker #(
   parameter int ID_BITS = nsts_pkg::ID_BITS_DEF
) (
   input wire                           clock,
   input wire                           reset,
   input wire                           req_ready,
   input wire                           rsp_valid,
   input wire                           rsp_ready,
   input wire                           rsp_found,
   input wire [ID_BITS-1:0]             rsp_best_id,
   input wire [nsts_pkg::DIST_W-1:0]    rsp_best_dist
);

   // A response held back by the consumer keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) &&
      $stable(rsp_best_id) && $stable(rsp_best_dist))
      else $error("response changed while stalled");

   // A search that selected nothing reports zero id and zero distance.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_best_id == '0 && rsp_best_dist == '0)
      else $error("empty response carries data");

   // In the cycle after reset no response is presented and requests are taken.
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && req_ready)
      else $error("response valid or request blocked straight after reset");

   // A fresh response needs an accepted request to pass through the whole pipeline after reset.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3)
      && !$past(reset, 4) && !$past(reset, 5))
      else $error("response appeared too soon after reset");

endmodule

bind nearest_sphere_target_select_top nsts_checker #(.ID_BITS(ID_BITS)) u_nsts_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_found     (rsp_found),
   .rsp_best_id   (rsp_best_id),
   .rsp_best_dist (rsp_best_dist)
);

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for nearest_sphere_target_select_top.
// Predicts each search result from the candidates accepted and checks responses in order.
// Depends on nsts_pkg and the top level of the block.
`timescale 1ns / 1ps

module tb;
   import nsts_pkg::*;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] radius;
      logic                      live;
      logic                      enabled;
      logic                      marked;
      logic [ID_BITS_DEF-1:0]    id;
      logic                      last;
   } sphere_cand_type;

   typedef struct {
      logic                   found;
      logic [ID_BITS_DEF-1:0] id;
      logic [DIST_W-1:0]      distance;
   } target_report_type;

   logic                        clock;
   logic                        reset            = 1'b1;
   logic                        csr_wr_en        = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index        = '0;
   logic [CSR_DATA_W-1:0]       csr_wdata        = '0;
   logic                        req_valid        = 1'b0;
   logic                        req_ready;
   logic signed [COORD_W-1:0]   req_cand_x       = '0;
   logic signed [COORD_W-1:0]   req_cand_y       = '0;
   logic signed [COORD_W-1:0]   req_cand_z       = '0;
   logic signed [COORD_W-1:0]   req_cand_radius  = '0;
   logic                        req_cand_live    = 1'b0;
   logic                        req_cand_enabled = 1'b0;
   logic                        req_cand_marked  = 1'b0;
   logic [ID_BITS_DEF-1:0]      req_cand_id      = '0;
   logic                        req_last_item    = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready        = 1'b0;
   logic                        rsp_found;
   logic [ID_BITS_DEF-1:0]      rsp_best_id;
   logic [DIST_W-1:0]           rsp_best_dist;

   // Predictor copy of the registers and of the selection held during a search.
   logic                        cfg_nearest      = 1'b0;
   logic signed [COORD_W-1:0]   cfg_self_x       = '0;
   logic signed [COORD_W-1:0]   cfg_self_y       = '0;
   logic signed [COORD_W-1:0]   cfg_self_z       = '0;
   logic signed [COORD_W-1:0]   cfg_self_radius  = '0;
   logic                        holding          = 1'b0;
   logic [ID_BITS_DEF-1:0]      held_id          = '0;
   logic [31:0]                 held_dist        = 32'(DIST_INIT);

   target_report_type pending_reports[$];
   int             mismatch_count   = 0;
   int             candidates_sent  = 0;
   int             send_idle_pct    = 20;
   int             recv_idle_pct    = 20;

   nearest_sphere_target_select_top #(
      .ID_BITS(ID_BITS_DEF)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cand_x       (req_cand_x),
      .req_cand_y       (req_cand_y),
      .req_cand_z       (req_cand_z),
      .req_cand_radius  (req_cand_radius),
      .req_cand_live    (req_cand_live),
      .req_cand_enabled (req_cand_enabled),
      .req_cand_marked  (req_cand_marked),
      .req_cand_id      (req_cand_id),
      .req_last_item    (req_last_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_best_id      (rsp_best_id),
      .rsp_best_dist    (rsp_best_dist)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end

   function automatic logic [31:0] surface_distance(input sphere_cand_type c);
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] dz;
      logic [63:0]        centre_sq;
      logic [63:0]        radius_sq;
      logic [31:0]        diff;
      dx = c.x - cfg_self_x;
      dy = c.y - cfg_self_y;
      dz = c.z - cfg_self_z;
      centre_sq = longint'(dx) * longint'(dx) + longint'(dy) * longint'(dy)
                + longint'(dz) * longint'(dz);
      radius_sq = longint'(cfg_self_radius) * longint'(cfg_self_radius)
                + longint'(c.radius) * longint'(c.radius);
      centre_sq = centre_sq + 64'(ROUND_ADD);
      radius_sq = radius_sq + 64'(ROUND_ADD);
      diff = centre_sq[FRAC_SHIFT +: 32] - radius_sq[FRAC_SHIFT +: 32];
      return diff[31] ? 32'd0 : diff;
   endfunction

   task automatic fold_candidate(input sphere_cand_type c);
      logic [31:0]       d;
      target_report_type report;
      if (c.live && c.enabled) begin
         if (cfg_nearest) begin
            d = surface_distance(c);
            if (d < held_dist) begin
               held_dist = d;
               held_id   = c.id;
               holding   = 1'b1;
            end
         end else if (!holding && !c.marked) begin
            held_dist = surface_distance(c);
            held_id   = c.id;
            holding   = 1'b1;
         end
      end
      if (c.last) begin
         report.found    = holding;
         report.id       = holding ? held_id : '0;
         report.distance = holding ? held_dist[DIST_W-1:0] : '0;
         pending_reports.push_back(report);
         holding   = 1'b0;
         held_id   = '0;
         held_dist = 32'(DIST_INIT);
      end
   endtask

   task automatic send_candidate(input sphere_cand_type c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cand_x       <= c.x;
      req_cand_y       <= c.y;
      req_cand_z       <= c.z;
      req_cand_radius  <= c.radius;
      req_cand_live    <= c.live;
      req_cand_enabled <= c.enabled;
      req_cand_marked  <= c.marked;
      req_cand_id      <= c.id;
      req_last_item    <= c.last;
      do @(posedge clock); while (!req_ready);
      candidates_sent++;
      fold_candidate(c);
   endtask

   // Holds requests back until every response has arrived and the pipeline is empty.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (PIPE_STAGES + 2) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_SELECT_NEAREST: cfg_nearest = value[0];
         CSR_SELF_X:         cfg_self_x = value;
         CSR_SELF_Y:         cfg_self_y = value;
         CSR_SELF_Z:         cfg_self_z = value;
         CSR_SELF_RADIUS:    cfg_self_radius = value;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [31:0] nearest, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z,
                             input logic [31:0] radius);
      drain_pipeline();
      csr_write(CSR_SELECT_NEAREST, nearest);
      csr_write(CSR_SELF_X, x);
      csr_write(CSR_SELF_Y, y);
      csr_write(CSR_SELF_Z, z);
      csr_write(CSR_SELF_RADIUS, radius);
   endtask

   function automatic sphere_cand_type make_cand(input logic [31:0] x, input logic [31:0] y,
                                             input logic [31:0] z, input logic [31:0] radius,
                                             input logic live, input logic enabled,
                                             input logic marked, input logic [15:0] id,
                                             input logic last);
      sphere_cand_type c;
      c.x       = x;
      c.y       = y;
      c.z       = z;
      c.radius  = radius;
      c.live    = live;
      c.enabled = enabled;
      c.marked  = marked;
      c.id      = id;
      c.last    = last;
      return c;
   endfunction

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(7))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2, 3:    return $urandom;
         default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
      endcase
   endfunction

   function automatic logic [31:0] near_coord(input logic [31:0] centre);
      if ($urandom_range(3) == 0)
         return $urandom;
      if ($urandom_range(1) == 0)
         return centre + 32'($urandom_range(0, 2048)) - 32'd1024;
      return centre + 32'($urandom_range(0, 131072)) - 32'd65536;
   endfunction

   function automatic sphere_cand_type random_candidate(input logic last);
      sphere_cand_type c;
      c.x       = near_coord(cfg_self_x);
      c.y       = near_coord(cfg_self_y);
      c.z       = near_coord(cfg_self_z);
      c.radius  = ($urandom_range(4) == 0) ? $urandom : $urandom_range(0, 16384);
      c.live    = ($urandom_range(9) != 0);
      c.enabled = ($urandom_range(9) != 0);
      c.marked  = ($urandom_range(9) < 3);
      c.id      = ID_BITS_DEF'($urandom);
      c.last    = last;
      return c;
   endfunction

   task automatic test_first_match();
      set_config(0, 0, 0, 0, 0);
      send_candidate(make_cand(5, 6, 7, 1, 0, 1, 0, 16'd1, 0));
      send_candidate(make_cand(5, 6, 7, 1, 1, 0, 0, 16'd2, 0));
      send_candidate(make_cand(5, 6, 7, 1, 1, 1, 1, 16'd3, 0));
      send_candidate(make_cand(32'h7fff_ffff, 0, 0, 0, 1, 1, 0, 16'd4, 0));
      send_candidate(make_cand(0, 0, 0, 0, 1, 1, 0, 16'd5, 0));
      send_candidate(make_cand(0, 0, 0, 0, 0, 0, 0, 16'd6, 1));
      // A search in which nothing qualifies reports zero id and distance.
      send_candidate(make_cand(1, 1, 1, 1, 0, 1, 0, 16'hffff, 1));
   endtask

   task automatic test_extreme_values();
      set_config(1, 32'h7fff_ffff, 32'h8000_0000, 0, 32'h7fff_ffff);
      send_candidate(make_cand(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                               32'h8000_0000, 1, 1, 1, 16'hffff, 0));
      send_candidate(make_cand(0, 0, 0, 0, 1, 1, 0, 16'h0000, 0));
      send_candidate(make_cand(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                               32'h7fff_ffff, 1, 1, 1, 16'h8000, 1));
      set_config(0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
      send_candidate(make_cand(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                               0, 1, 1, 0, 16'h7fff, 1));
   endtask

   task automatic test_nearest_bound_and_ties();
      set_config(1, 0, 0, 0, 0);
      // This centre lies at a rounded squared distance of exactly the initial bound.
      send_candidate(make_cand(2965820, 2177, 66, 0, 1, 1, 0, 16'd10, 1));
      send_candidate(make_cand(4096, 0, 0, 0, 1, 1, 0, 16'd20, 0));
      send_candidate(make_cand(0, 4096, 0, 0, 1, 1, 0, 16'd21, 0));
      send_candidate(make_cand(0, 0, 4096, 0, 1, 1, 1, 16'd22, 1));
      send_candidate(make_cand(100, 0, 0, 32'h0010_0000, 1, 1, 1, 16'd23, 1));
      drain_pipeline();
      csr_write(CSR_SELECT_NEAREST, 0);
      send_candidate(make_cand(2965820, 2177, 66, 0, 1, 1, 0, 16'd11, 1));
   endtask

   task automatic test_mode_change_mid_search();
      set_config(0, 1000, -1000, 0, 16);
      send_candidate(make_cand(900000, 0, 0, 16, 1, 1, 0, 16'd30, 0));
      drain_pipeline();
      csr_write(CSR_SELECT_NEAREST, 1);
      send_candidate(make_cand(1000, -1000, 500, 16, 1, 1, 1, 16'd31, 1));
      send_candidate(make_cand(2000, 0, 0, 8, 1, 1, 0, 16'd40, 0));
      drain_pipeline();
      csr_write(CSR_SELECT_NEAREST, 0);
      send_candidate(make_cand(1000, -1000, 0, 0, 1, 1, 0, 16'd41, 1));
   endtask

   task automatic test_random_searches(input int count);
      int target;
      int round_end;
      int len;
      target = candidates_sent + count;
      while (candidates_sent < target) begin
         set_config($urandom_range(1), pick_coord(), pick_coord(), pick_coord(),
                    ($urandom_range(3) == 0) ? pick_coord() : $urandom_range(0, 16384));
         round_end = candidates_sent + $urandom_range(30, 90);
         while (candidates_sent < round_end && candidates_sent < target) begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
               send_candidate(random_candidate(i == len - 1));
            if ($urandom_range(24) == 0)
               drain_pipeline();
         end
      end
   endtask

   always @(posedge clock) begin
      target_report_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_valid && rsp_ready) begin
            if (pending_reports.size() == 0) begin
               $error("response with no search outstanding: found %0b id %0h dist %0h",
                      rsp_found, rsp_best_id, rsp_best_dist);
               mismatch_count++;
            end else begin
               want = pending_reports.pop_front();
               if (rsp_found !== want.found) begin
                  $error("found: expected %0b, got %0b", want.found, rsp_found);
                  mismatch_count++;
               end
               if (rsp_best_id !== want.id) begin
                  $error("best_id: expected %0h, got %0h", want.id, rsp_best_id);
                  mismatch_count++;
               end
               if (rsp_best_dist !== want.distance) begin
                  $error("best_dist: expected %0h, got %0h", want.distance, rsp_best_dist);
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_first_match();
      test_extreme_values();
      test_nearest_bound_and_ties();
      test_mode_change_mid_search();
      send_idle_pct = 33;
      recv_idle_pct = 86;
      test_random_searches(450);
      drain_pipeline();
      send_idle_pct = 86;
      recv_idle_pct = 33;
      test_random_searches(450);
      drain_pipeline();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_searches(450);
      drain_pipeline();
      repeat (PIPE_STAGES + 4) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
